// ===== rtl/core/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared widths, codes and types of the min priority queue cell chain.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int DEPTH     = 256;
	localparam int LINK_BITS = 9;
	localparam int FREQ_W    = 20;
	localparam int SYM_W     = 8;
	localparam int COUNT_W   = $clog2(DEPTH + 1);

	localparam logic [FREQ_W-1:0] FREQ_LIMIT = FREQ_W'(1000000);

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_PUSH = 2'd0;
	localparam mode_t MODE_PEEK = 2'd1;
	localparam mode_t MODE_POP  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_FREQ_BIG = 2'd3
	} status_t;

	typedef struct packed {
		logic [FREQ_W-1:0]    freq;
		logic [SYM_W-1:0]     symbol;
		logic [LINK_BITS-1:0] left;
		logic [LINK_BITS-1:0] right;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_cmd_t;

endpackage

// ===== rtl/core/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain. Keeps its entry, takes the new word or its
// upper neighbor's entry on push, takes its lower neighbor's entry on pop.
// ----------------------------------------------------------------------------
module mpq_cell (
	input  logic               clk,
	input  mpq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  mpq_pkg::entry_t    new_entry,
	input  mpq_pkg::entry_t    prev_entry,
	input  mpq_pkg::entry_t    next_entry,
	input  logic               prev_keep,
	output mpq_pkg::entry_t    entry,
	output logic               keep
);

	mpq_pkg::entry_t entry_q;

	// strictly less: an equal new word goes ahead of older ones
	assign keep  = occupied && (entry_q.freq < new_entry.freq);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= next_entry;
		end else if (cmd.push && !keep) begin
			if (prev_keep) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= prev_entry;
			end
		end
	end

endmodule

// ===== rtl/core/min_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_unit
// Bounded min priority queue of tree nodes held sorted in a chain of cells,
// least frequency (newest among equals) at the head.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  req     | req_valid / req_ready | mode, entry_frequency, entry_symbol,
//          |                       | entry_left, entry_right
//  rsp     | rsp_valid / rsp_ready | out_frequency, out_symbol, out_left,
//          |                       | out_right, count, status
//
//  a word is captured in the s1 register and executed on the chain from
//  there; no new word is taken while one is pending. The chain update is
//  the single compare against the new word in every cell plus the neighbor mux.
//  reset clears the count and both valid flags; cell contents are left as
//  they are.
//  a result waiting in the output register holds the pending word back.
// ----------------------------------------------------------------------------
module min_priority_queue_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [1:0]                      mode,
	input  logic [mpq_pkg::FREQ_W-1:0]      entry_frequency,
	input  logic [mpq_pkg::SYM_W-1:0]       entry_symbol,
	input  logic [mpq_pkg::LINK_BITS-1:0]   entry_left,
	input  logic [mpq_pkg::LINK_BITS-1:0]   entry_right,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [mpq_pkg::FREQ_W-1:0]      out_frequency,
	output logic [mpq_pkg::SYM_W-1:0]       out_symbol,
	output logic [mpq_pkg::LINK_BITS-1:0]   out_left,
	output logic [mpq_pkg::LINK_BITS-1:0]   out_right,
	output logic [mpq_pkg::COUNT_W-1:0]     count,
	output logic [1:0]                      status
);

	logic                         op_valid_s1;
	mpq_pkg::mode_t               mode_s1;
	mpq_pkg::entry_t              entry_s1;

	logic [mpq_pkg::COUNT_W-1:0]  count_q;
	logic [mpq_pkg::COUNT_W-1:0]  count_next;

	logic                         rsp_valid_q;
	mpq_pkg::entry_t              rsp_entry_q;
	logic [mpq_pkg::COUNT_W-1:0]  rsp_count_q;
	mpq_pkg::status_t             rsp_status_q;

	logic                         exec;
	logic                         full;
	logic                         empty;
	logic                         freq_big;
	mpq_pkg::cell_cmd_t           cmd;
	mpq_pkg::entry_t              res_entry;
	mpq_pkg::status_t             res_status;

	mpq_pkg::entry_t              cell_entry [mpq_pkg::DEPTH];
	logic                         cell_keep  [mpq_pkg::DEPTH];

	assign req_ready = !op_valid_s1;
	assign exec      = op_valid_s1 && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			op_valid_s1 <= 1'b1;
		end else if (exec) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			mode_s1         <= mode;
			entry_s1.freq   <= entry_frequency;
			entry_s1.symbol <= entry_symbol;
			entry_s1.left   <= entry_left;
			entry_s1.right  <= entry_right;
		end
	end

	assign full     = (count_q == mpq_pkg::COUNT_W'(mpq_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign freq_big = (entry_s1.freq >= mpq_pkg::FREQ_LIMIT);

	always_comb begin
		cmd        = '0;
		res_entry  = '0;
		res_status = mpq_pkg::ST_OK;
		count_next = count_q;
		case (mode_s1)
			mpq_pkg::MODE_PUSH: begin
				if (full) begin
					res_status = mpq_pkg::ST_FULL;
				end else if (freq_big) begin
					res_status = mpq_pkg::ST_FREQ_BIG;
				end else begin
					cmd.push   = exec;
					count_next = count_q + mpq_pkg::COUNT_W'(1);
				end
			end
			mpq_pkg::MODE_PEEK, mpq_pkg::MODE_POP: begin
				if (empty) begin
					res_status = mpq_pkg::ST_EMPTY;
				end else begin
					res_entry = cell_entry[0];
					if (mode_s1 == mpq_pkg::MODE_POP) begin
						cmd.pop    = exec;
						count_next = count_q - mpq_pkg::COUNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// cell chain, head at index 0
	for (genvar i = 0; i < mpq_pkg::DEPTH; i++) begin : g_cell
		mpq_pkg::entry_t prev_entry;
		mpq_pkg::entry_t next_entry;
		logic            prev_keep;

		if (i == 0) begin : g_head
			assign prev_entry = entry_s1;
			assign prev_keep  = 1'b1;
		end else begin : g_body
			assign prev_entry = cell_entry[i-1];
			assign prev_keep  = cell_keep[i-1];
		end

		if (i == mpq_pkg::DEPTH - 1) begin : g_tail
			assign next_entry = cell_entry[i];
		end else begin : g_link
			assign next_entry = cell_entry[i+1];
		end

		mpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (mpq_pkg::COUNT_W'(i) < count_q),
			.new_entry  (entry_s1),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.prev_keep  (prev_keep),
			.entry      (cell_entry[i]),
			.keep       (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				count_q <= count_next;
			end
			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_entry_q  <= res_entry;
			rsp_count_q  <= count_next;
			rsp_status_q <= res_status;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign out_frequency = rsp_entry_q.freq;
	assign out_symbol    = rsp_entry_q.symbol;
	assign out_left      = rsp_entry_q.left;
	assign out_right     = rsp_entry_q.right;
	assign count         = rsp_count_q;
	assign status        = rsp_status_q;

`ifndef NO_ASSERTIONS
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q == $past(count_q) + mpq_pkg::COUNT_W'(1))
		else $error("push did not grow the count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= mpq_pkg::COUNT_W'(2)) |-> (cell_entry[0].freq <= cell_entry[1].freq))
		else $error("chain head out of order");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q == mpq_pkg::ST_EMPTY) |-> (rsp_count_q == '0))
		else $error("empty status with nonzero count");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop on the chain together");
`endif

endmodule
